// ===== rtl/core/gpsl_pkg.sv =====
package gpsl_pkg;

	// sizes
	localparam int NUM_CHANNELS = 4;
	localparam int DEG_W        = 16;
	localparam int POS_W        = 17;
	localparam int CH_FIELD_W   = 2;
	localparam int NUM_ZERO     = 4;
	localparam int MASK_W       = 4;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int IN_TDATA_W   = 24;
	localparam int OUT_TDATA_W  = 24;

	// register reset values
	localparam logic [DEG_W-1:0] STEP_RST = 16'd1;
	localparam logic [DEG_W-1:0] MAX_RST  = 16'hFFFF;

	// beat kinds
	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_SET  = 2'd1,
		OP_GET  = 2'd2,
		OP_INIT = 2'd3
	} op_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CW_MASK = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 3'd6;

	// controller -> datapath
	typedef struct packed {
		logic                  latch;    // capture input beat
		logic                  step;     // process one channel
		logic [CH_FIELD_W-1:0] idx;      // walk index
		logic                  load_out; // move result into output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic walk; // captured op visits every channel
	} dp_sts_t;

endpackage

// ===== rtl/core/gpsl_ctrl.sv =====
module gpsl_ctrl #(
	parameter int CHANNELS = gpsl_pkg::NUM_CHANNELS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              m_tready,
	output logic              m_tvalid,
	output gpsl_pkg::dp_cmd_t cmd,
	input  gpsl_pkg::dp_sts_t sts
);
	import gpsl_pkg::*;

	localparam logic [CH_FIELD_W-1:0] LAST_IDX = CH_FIELD_W'(CHANNELS - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                state_q;
	state_t                state_d;
	logic [CH_FIELD_W-1:0] idx_q;
	logic                  out_valid_q;
	logic                  accept;
	logic                  last;
	logic                  load_out;

	assign accept   = s_tvalid && (state_q == ST_IDLE);
	assign last     = !sts.walk || (idx_q == LAST_IDX);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) idx_q <= '0;
			else if (state_q == ST_RUN) idx_q <= idx_q + 1'b1;
			if (load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign s_tready     = (state_q == ST_IDLE);
	assign m_tvalid     = out_valid_q;
	assign cmd.latch    = accept;
	assign cmd.step     = (state_q == ST_RUN);
	assign cmd.idx      = idx_q;
	assign cmd.load_out = load_out;

endmodule

// ===== rtl/core/gpsl_dp.sv =====
module gpsl_dp #(
	parameter int CHANNELS = gpsl_pkg::NUM_CHANNELS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [gpsl_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  logic [1:0]                           s_tuser,
	output logic [gpsl_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                 cfg_we,
	input  logic [gpsl_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [gpsl_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  gpsl_pkg::dp_cmd_t                    cmd,
	output gpsl_pkg::dp_sts_t                    sts
);
	import gpsl_pkg::*;

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PAD_W = OUT_TDATA_W - 1 - POS_W;

	// configuration
	logic [DEG_W-1:0]  zero_q [NUM_ZERO];
	logic [MASK_W-1:0] cw_q;
	logic [DEG_W-1:0]  step_q;
	logic [DEG_W-1:0]  max_q;

	// captured beat
	op_t                   op_q;
	logic [CH_FIELD_W-1:0] chan_q;
	logic [DEG_W-1:0]      deg_q;

	// channel state
	logic [DEG_W-1:0] cmd_pos_q [CHANNELS];
	logic [DEG_W-1:0] ramp_q    [CHANNELS];
	logic [POS_W-1:0] cur_q     [CHANNELS];

	// result and output registers
	logic             res_status_q;
	logic [POS_W-1:0] res_pos_q;
	logic             out_status_q;
	logic [POS_W-1:0] out_pos_q;

	logic [CH_FIELD_W-1:0] addr;
	logic [CH_W-1:0]       ai;
	logic [DEG_W-1:0]      c;
	logic [DEG_W-1:0]      r;
	logic [DEG_W-1:0]      zero_sel;
	logic                  cw_sel;
	logic [POS_W-1:0]      up_sum;
	logic [POS_W-1:0]      dn_sum;
	logic [DEG_W-1:0]      r_next;
	logic                  moving;
	logic [POS_W-1:0]      cw_sum;
	logic [POS_W-1:0]      ccw_dif;
	logic [POS_W:0]        ccw_wrap;
	logic [POS_W-1:0]      mapped;
	logic                  bad_ch;
	logic                  bad_deg;

	assign sts.walk = (op_q == OP_TICK) || (op_q == OP_INIT);
	assign addr     = sts.walk ? cmd.idx : chan_q;
	assign ai       = addr[CH_W-1:0];
	assign c        = cmd_pos_q[ai];
	assign r        = ramp_q[ai];
	assign zero_sel = zero_q[addr];
	assign cw_sel   = cw_q[addr];

	// slew toward command, clamped to at most one step
	assign up_sum = {1'b0, r} + {1'b0, step_q};
	assign dn_sum = {1'b0, c} + {1'b0, step_q};
	assign moving = (c != r);

	always_comb begin
		if (c > r) r_next = ({1'b0, c} > up_sum) ? up_sum[DEG_W-1:0] : c;
		else       r_next = (dn_sum < {1'b0, r}) ? (r - step_q) : c;
	end

	// pointer mapping; ccw wraps by max_degree, then mod 2^17
	assign cw_sum   = {1'b0, zero_sel} + {1'b0, r_next};
	assign ccw_dif  = {1'b0, zero_sel} - {1'b0, r_next};
	assign ccw_wrap = {2'b00, max_q} + {2'b00, zero_sel} - {2'b00, r_next};

	always_comb begin
		if (cw_sel)                  mapped = cw_sum;
		else if (zero_sel >= r_next) mapped = ccw_dif;
		else                         mapped = ccw_wrap[POS_W-1:0];
	end

	assign bad_ch  = ({1'b0, chan_q} >= (CH_FIELD_W + 1)'(CHANNELS));
	assign bad_deg = (deg_q > max_q);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ZERO; i++) zero_q[i] <= '0;
			cw_q   <= '0;
			step_q <= STEP_RST;
			max_q  <= MAX_RST;
		end else if (cfg_we) begin
			case (cfg_addr) inside
				[CFG_ZERO0:CFG_ZERO3]: zero_q[cfg_addr[1:0]] <= cfg_wdata;
				CFG_CW_MASK:           cw_q   <= cfg_wdata[MASK_W-1:0];
				CFG_STEP:              step_q <= cfg_wdata;
				CFG_MAX:               max_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// channel state and captured op
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_TICK;
			for (int i = 0; i < CHANNELS; i++) begin
				cmd_pos_q[i] <= '0;
				ramp_q[i]    <= '0;
				cur_q[i]     <= '0;
			end
		end else begin
			if (cmd.latch) op_q <= op_t'(s_tuser);
			if (cmd.step) begin
				case (op_q)
					OP_TICK: begin
						if (moving) begin
							ramp_q[ai] <= r_next;
							cur_q[ai]  <= mapped;
						end
					end
					OP_SET: begin
						if (!bad_ch && !bad_deg) cmd_pos_q[ai] <= deg_q;
					end
					OP_INIT: begin
						cmd_pos_q[ai] <= zero_sel;
						ramp_q[ai]    <= zero_sel;
						cur_q[ai]     <= {1'b0, zero_sel};
					end
					default: ;
				endcase
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			chan_q       <= s_tdata[CH_FIELD_W-1:0];
			deg_q        <= s_tdata[CH_FIELD_W +: DEG_W];
			res_status_q <= 1'b0;
			res_pos_q    <= '0;
		end else if (cmd.step) begin
			case (op_q)
				OP_SET: res_status_q <= bad_ch || bad_deg;
				OP_GET: begin
					res_status_q <= bad_ch;
					res_pos_q    <= bad_ch ? '0 : cur_q[ai];
				end
				default: ;
			endcase
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_pos_q    <= res_pos_q;
		end
	end

	assign m_tdata = {{PAD_W{1'b0}}, out_pos_q, out_status_q};

endmodule

// ===== rtl/core/gauge_pointer_slew_limiter_unit.sv =====
// Multi-channel gauge pointer slew limiter.
// Input stream (s_*): one beat per operation. s_tuser carries the op
// (tick, set command, get position, init from zeros); s_tdata carries
// channel and degree. Every input beat yields exactly one output beat on
// m_* with a status bit (0 ok, 1 rejected) and a 17-bit position that is
// nonzero only for an accepted get.
// Config port (cfg_we/cfg_addr/cfg_wdata): registers 0-3 software zeros,
// 4 clockwise mask, 5 step size, 6 max degree. Write only while idle.
// Sequence: set/get visit one channel in the datapath, tick/init walk the
// channels one per cycle, then the result is loaded into the output
// register, which raises m_tvalid. One beat is in flight at a time: a
// new beat is not accepted until the current result has left the datapath.
// The single output register lets the block take the next beat while a
// result still waits; if the receiver stalls, the following result parks
// in the datapath and s_tready stays low until the output drains.
// Reset clears all channel state to zero, step size to 1 and max degree
// to 65535; no beat is valid on the output after reset.
module gauge_pointer_slew_limiter_unit #(
	parameter int CHANNELS = gpsl_pkg::NUM_CHANNELS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [gpsl_pkg::IN_TDATA_W-1:0]    s_tdata,  // [1:0] channel, [17:2] degree
	input  logic [1:0]                         s_tuser,  // [1:0] op
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [gpsl_pkg::OUT_TDATA_W-1:0]   m_tdata,  // [0] status, [17:1] position
	input  logic                               cfg_we,
	input  logic [gpsl_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [gpsl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import gpsl_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer: accept, channel walk, output handoff
	gpsl_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd),
		.sts      (sts)
	);

	// config, channel state, slew and mapping math, result registers
	gpsl_dp #(.CHANNELS(CHANNELS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
